FILE: rtl/core/pmq_pkg.sv
package pmq_pkg;

	// queue geometry
	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// action codes
	localparam logic [2:0] ACT_APPEND = 3'd0;
	localparam logic [2:0] ACT_INSERT = 3'd1;
	localparam logic [2:0] ACT_POP    = 3'd2;
	localparam logic [2:0] ACT_PEEK   = 3'd3;
	localparam logic [2:0] ACT_TAKE   = 3'd4;
	localparam logic [2:0] ACT_FIND   = 3'd5;
	localparam logic [2:0] ACT_CLEAR  = 3'd6;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// one queue entry, first field in the highest bits
	typedef struct packed {
		logic [31:0] payload;
		logic [15:0] msg_id;
		logic [7:0]  msg_type;
		logic [7:0]  prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);
	localparam int OUT_W   = ENTRY_W + CNT_W;
	localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

	// command broadcast to every cell
	typedef struct packed {
		logic       exec;
		logic [2:0] op;
		logic       full;
		entry_t     ent;
	} ctl_t;

endpackage

FILE: rtl/core/pmq_cell.sv
module pmq_cell (
	input  logic            clk,
	input  pmq_pkg::ctl_t   ctl,
	input  logic            occ,       // cell holds a live entry
	input  logic            tail,      // cell is the first free slot
	input  logic            any_hit,   // some cell of the row matched
	input  logic            hit_in,    // an earlier cell matched
	output logic            hit_out,
	input  pmq_pkg::entry_t left,
	input  pmq_pkg::entry_t right,
	output pmq_pkg::entry_t entry,
	output pmq_pkg::entry_t found
);

	pmq_pkg::entry_t entry_q;
	logic            hit;
	logic            first;
	logic            is_ins;

	// local match for insert position or type search
	always_comb begin
		is_ins = (ctl.op == pmq_pkg::ACT_APPEND) || (ctl.op == pmq_pkg::ACT_INSERT);
		hit    = 1'b0;
		unique case (ctl.op) inside
			pmq_pkg::ACT_INSERT: hit = occ && (ctl.ent.prio > entry_q.prio);
			pmq_pkg::ACT_TAKE,
			pmq_pkg::ACT_FIND:   hit = occ && (entry_q.msg_type == ctl.ent.msg_type);
			default:             hit = 1'b0;
		endcase
		hit_out = hit_in | hit;
		first   = hit & ~hit_in;
	end

	// entry update: load, shift toward tail, or shift toward head
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			if (is_ins && !ctl.full) begin
				if (first || (tail && !any_hit))
					entry_q <= ctl.ent;
				else if (hit_in)
					entry_q <= left;
			end else if (ctl.op == pmq_pkg::ACT_POP) begin
				entry_q <= right;
			end else if (ctl.op == pmq_pkg::ACT_TAKE && hit_out) begin
				entry_q <= right;
			end
		end
	end

	assign entry = entry_q;
	assign found = first ? entry_q : '0;

endmodule

FILE: rtl/core/priority_message_queue.sv
// an accepted transaction is captured in op_q and ent_q; the row of cells
// updates in the cycle after accept, together with the result register, and
// the next item is taken once busy_q drops and the result register is free
// reset: arst_n clears the fill count and the handshake state at once; the
// entry cells hold no reset value and are only read below the fill count
module priority_message_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// prio, msg_type, msg_id, payload_handle
	input  logic [pmq_pkg::ENTRY_W-1:0] s_axis_tdata,
	// action
	input  logic [2:0]                  s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// out_prio, out_type, out_id, out_payload, fill_count, zero fill
	output logic [pmq_pkg::OUT_TW-1:0]  m_axis_tdata,
	// status
	output logic [1:0]                  m_axis_tuser
);

	localparam int D = pmq_pkg::DEPTH;
	localparam int W = pmq_pkg::CNT_W;

	logic                          busy_q;
	logic                          out_valid_q;
	logic [W-1:0]                  count_q;
	logic [2:0]                    op_q;
	pmq_pkg::entry_t               ent_q;
	pmq_pkg::entry_t               out_ent_q;
	logic [1:0]                    out_status_q;
	logic [W-1:0]                  out_count_q;

	pmq_pkg::ctl_t                 ctl;
	logic                          accept;
	logic                          full;
	logic                          empty;
	logic                          any_hit;
	logic [D-1:0]                  occ;
	logic [D-1:0]                  tail;
	logic [D:0]                    hit_chain;
	pmq_pkg::entry_t [D-1:0]       cell_ent;
	pmq_pkg::entry_t [D-1:0]       cell_found;
	pmq_pkg::entry_t               found_ent;
	pmq_pkg::entry_t               res_ent;
	logic [1:0]                    res_status;
	logic [W-1:0]                  res_count;

	// input handshake: one transaction at a time, result register must be free
	assign s_axis_tready = !busy_q && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= accept;
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_axis_tuser;
			ent_q <= pmq_pkg::entry_t'(s_axis_tdata);
		end
	end

	assign full  = (count_q == W'(D));
	assign empty = (count_q == '0);

	always_comb begin
		ctl.exec = busy_q;
		ctl.op   = op_q;
		ctl.full = full;
		ctl.ent  = ent_q;
	end

	// occupancy and tail marks per cell
	always_comb begin
		for (int i = 0; i < D; i++) begin
			occ[i]  = W'(i) < count_q;
			tail[i] = W'(i) == count_q;
		end
	end

	// row of cells
	assign hit_chain[0] = 1'b0;
	assign any_hit      = hit_chain[D];

	for (genvar g = 0; g < D; g++) begin : g_cell
		pmq_pkg::entry_t lft;
		pmq_pkg::entry_t rgt;

		if (g == 0) begin : g_first
			assign lft = '0;
		end else begin : g_mid_l
			assign lft = cell_ent[g-1];
		end
		if (g == D - 1) begin : g_last
			assign rgt = '0;
		end else begin : g_mid_r
			assign rgt = cell_ent[g+1];
		end

		pmq_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.occ     (occ[g]),
			.tail    (tail[g]),
			.any_hit (any_hit),
			.hit_in  (hit_chain[g]),
			.hit_out (hit_chain[g+1]),
			.left    (lft),
			.right   (rgt),
			.entry   (cell_ent[g]),
			.found   (cell_found[g])
		);
	end

	// merge the single matching entry
	always_comb begin
		found_ent = '0;
		for (int i = 0; i < D; i++)
			found_ent = found_ent | cell_found[i];
	end

	// result and next fill count
	always_comb begin
		res_ent    = '0;
		res_status = pmq_pkg::ST_OK;
		res_count  = count_q;
		unique case (op_q) inside
			pmq_pkg::ACT_APPEND,
			pmq_pkg::ACT_INSERT: begin
				if (full)
					res_status = pmq_pkg::ST_FULL;
				else
					res_count = count_q + W'(1);
			end
			pmq_pkg::ACT_POP,
			pmq_pkg::ACT_PEEK: begin
				if (empty) begin
					res_status = pmq_pkg::ST_EMPTY;
				end else begin
					res_ent = cell_ent[0];
					if (op_q == pmq_pkg::ACT_POP)
						res_count = count_q - W'(1);
				end
			end
			pmq_pkg::ACT_TAKE,
			pmq_pkg::ACT_FIND: begin
				if (!any_hit) begin
					res_status = pmq_pkg::ST_EMPTY;
				end else begin
					res_ent = found_ent;
					if (op_q == pmq_pkg::ACT_TAKE)
						res_count = count_q - W'(1);
				end
			end
			pmq_pkg::ACT_CLEAR: res_count = '0;
			default: res_count = count_q;
		endcase
	end

	// fill count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (busy_q)
				count_q <= res_count;
			if (busy_q)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (busy_q) begin
			out_ent_q    <= res_ent;
			out_status_q <= res_status;
			out_count_q  <= res_count;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {{(pmq_pkg::OUT_TW - pmq_pkg::OUT_W){1'b0}}, out_count_q, out_ent_q};

endmodule

FILE: rtl/core/pmq_checker.sv
module pmq_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [pmq_pkg::OUT_TW-1:0] m_axis_tdata,
	input logic [1:0]                 m_axis_tuser
);

	logic [pmq_pkg::CNT_W-1:0] fill;

	assign fill = m_axis_tdata[pmq_pkg::ENTRY_W +: pmq_pkg::CNT_W];

	// a stalled result keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// one transaction at a time: no accept in the cycle after an accept
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while busy");

	// every accepted transaction yields a valid result after the busy cycle
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
		else $error("result missing");

	// fill count never exceeds the depth
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> fill <= pmq_pkg::CNT_W'(pmq_pkg::DEPTH))
		else $error("fill count beyond depth");

	// a refused insert only happens on a full queue
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == pmq_pkg::ST_FULL
		|-> fill == pmq_pkg::CNT_W'(pmq_pkg::DEPTH))
		else $error("full status with room left");

endmodule

bind priority_message_queue pmq_checker u_pmq_checker (.*);
